// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of the LED group animator.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables the check.
`define LGA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define LGA_ASSERT(lbl, prop, msg) `LGA_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ----- hdl/lga_pkg.sv -----
// Package for the LED group animator: types, codes and constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lga_pkg;

    localparam int CHANNELS_DEF = 4;   // default channel count
    localparam int NUM_OUT      = 4;   // level outputs on the ports
    localparam int BRIGHT_W     = 8;
    localparam int LEVEL_W      = 16;
    localparam int PERIOD_W     = 16;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic [BRIGHT_W-1:0] FADE_STEP  = 8'd5;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 8'hFF;
    localparam logic [NUM_OUT-1:0]  PRESENT_ALL = 4'hF;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_SOLID = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_FADE  = 2'd3
    } t_mode;

    typedef enum logic [0:0] {
        REG_MAX_BRIGHT = 1'b0,
        REG_CH_PRESENT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [BRIGHT_W-1:0] max_brightness;
        logic [NUM_OUT-1:0]  channel_present;
    } t_cfg;

    typedef struct packed {
        logic [BRIGHT_W-1:0] bright;
        logic                rising;
    } t_fade;

endpackage

// ----- hdl/lga_fade.sv -----
// One fade step of the brightness: up or down by the fade step, bouncing at 0 and max.
// Depends on lga_pkg.
`timescale 1ns / 1ps

module lga_fade (
    input  logic [lga_pkg::BRIGHT_W-1:0] i_bright,
    input  logic                         i_rising,
    input  logic [lga_pkg::BRIGHT_W-1:0] i_max,
    output lga_pkg::t_fade               o_fade
);
    import lga_pkg::*;

    logic [BRIGHT_W:0] w_sum;

    assign w_sum = {1'b0, i_bright} + {1'b0, FADE_STEP};

    always_comb begin
        if (i_rising) begin
            // A level above a lowered maximum also lands on the maximum.
            if (w_sum >= {1'b0, i_max}) begin
                o_fade.bright = i_max;
                o_fade.rising = 1'b0;
            end else begin
                o_fade.bright = w_sum[BRIGHT_W-1:0];
                o_fade.rising = 1'b1;
            end
        end else if (i_bright <= FADE_STEP) begin
            o_fade.bright = '0;
            o_fade.rising = 1'b1;
        end else begin
            o_fade.bright = i_bright - FADE_STEP;
            o_fade.rising = 1'b0;
        end
    end

endmodule

// ----- hdl/lga_cfg.sv -----
// APB-style configuration registers of the LED group animator.
// Depends on lga_pkg.
`timescale 1ns / 1ps

module lga_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lga_pkg::ADDR_W-1:0] paddr,
    input  logic [lga_pkg::DATA_W-1:0] pwdata,
    output logic [lga_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output lga_pkg::t_cfg              o_cfg
);
    import lga_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_brightness  <= BRIGHT_MAX;
            r_cfg.channel_present <= PRESENT_ALL;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MAX_BRIGHT: r_cfg.max_brightness  <= pwdata[BRIGHT_W-1:0];
                REG_CH_PRESENT: r_cfg.channel_present <= pwdata[NUM_OUT-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MAX_BRIGHT: prdata = {{(DATA_W-BRIGHT_W){1'b0}}, r_cfg.max_brightness};
            REG_CH_PRESENT: prdata = {{(DATA_W-NUM_OUT){1'b0}}, r_cfg.channel_present};
            default:        prdata = '0;
        endcase
    end

endmodule

// ----- hdl/lga_core.sv -----
// Animation state, per-tick update and result handshake of the LED group animator.
// Depends on lga_pkg and lga_fade.
`timescale 1ns / 1ps

module lga_core #(
    parameter int CHANNELS = lga_pkg::CHANNELS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  lga_pkg::t_cfg                           i_cfg,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [1:0]                              i_anim_mode,
    input  logic [lga_pkg::NUM_OUT-1:0]             i_led_mask,
    input  logic [lga_pkg::PERIOD_W-1:0]            i_period_ms,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [lga_pkg::NUM_OUT-1:0][lga_pkg::LEVEL_W-1:0] o_levels,
    output logic [lga_pkg::NUM_OUT-1:0]             o_lit_pattern
);
    import lga_pkg::*;

    // Only the first four channels have ports and storage.
    localparam int NCH = (CHANNELS < NUM_OUT) ? CHANNELS : NUM_OUT;

    logic                r_valid;
    logic                r_mode_seen;
    t_mode               r_last_mode;
    logic [NUM_OUT-1:0]  r_pattern;
    logic [BRIGHT_W-1:0] r_bright;
    logic                r_rising;
    logic [PERIOD_W-1:0] r_ticks_left;
    logic [LEVEL_W-1:0]  r_levels [NCH];

    logic [NUM_OUT-1:0]  w_chan_bits;
    t_mode               w_mode;
    logic                w_acc;
    logic                w_any;
    logic                w_mode_chg;
    logic                w_act;
    logic [PERIOD_W-1:0] w_tl_dec;
    logic [BRIGHT_W-1:0] w_b_base;
    logic                w_rise_base;
    t_fade               w_fade;
    logic [NUM_OUT-1:0]  n_pattern;
    logic [BRIGHT_W-1:0] n_bright;
    logic                n_rising;
    logic [PERIOD_W-1:0] n_ticks_left;
    logic [LEVEL_W-1:0]  w_square;

    assign w_mode  = t_mode'(i_anim_mode);
    assign o_ready = !r_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_valid;

    always_comb begin
        for (int i = 0; i < NUM_OUT; i++) begin
            w_chan_bits[i] = (i < NCH);
        end
    end

    assign w_tl_dec    = (r_ticks_left != '0) ? r_ticks_left - 16'd1 : r_ticks_left;
    assign w_any       = |i_cfg.channel_present;
    assign w_mode_chg  = w_any && (!r_mode_seen || (w_mode != r_last_mode));
    assign w_act       = w_any && (w_mode_chg || (w_tl_dec == '0));
    assign w_b_base    = w_mode_chg ? i_cfg.max_brightness : r_bright;
    assign w_rise_base = w_mode_chg ? 1'b0 : r_rising;

    lga_fade u_fade (
        .i_bright (w_b_base),
        .i_rising (w_rise_base),
        .i_max    (i_cfg.max_brightness),
        .o_fade   (w_fade)
    );

    always_comb begin
        n_pattern    = r_pattern;
        n_bright     = w_b_base;
        n_rising     = w_rise_base;
        n_ticks_left = w_mode_chg ? '0 : w_tl_dec;
        if (w_act) begin
            case (w_mode)
                MODE_OFF:   n_pattern = '0;
                MODE_SOLID: n_pattern = i_led_mask;
                MODE_BLINK: n_pattern = ~r_pattern & i_led_mask;
                MODE_FADE: begin
                    n_pattern = r_pattern & i_led_mask;
                    n_bright  = w_fade.bright;
                    n_rising  = w_fade.rising;
                end
                default: ;
            endcase
            if (w_mode inside {MODE_BLINK, MODE_FADE}) begin
                n_ticks_left = i_period_ms;
            end
            n_pattern = n_pattern & w_chan_bits;
        end
    end

    assign w_square = {{(LEVEL_W-BRIGHT_W){1'b0}}, n_bright}
                    * {{(LEVEL_W-BRIGHT_W){1'b0}}, n_bright};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_mode_seen  <= 1'b0;
            r_last_mode  <= MODE_OFF;
            r_pattern    <= '0;
            r_bright     <= BRIGHT_MAX;
            r_rising     <= 1'b0;
            r_ticks_left <= '0;
            for (int i = 0; i < NCH; i++) begin
                r_levels[i] <= '0;
            end
        end else begin
            if (w_acc) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_acc) begin
                r_ticks_left <= n_ticks_left;
                if (w_mode_chg) begin
                    r_mode_seen <= 1'b1;
                    r_last_mode <= w_mode;
                end
                if (w_act) begin
                    r_pattern <= n_pattern;
                    r_bright  <= n_bright;
                    r_rising  <= n_rising;
                    for (int i = 0; i < NCH; i++) begin
                        if (i_cfg.channel_present[i]) begin
                            r_levels[i] <= n_pattern[i] ? w_square : '0;
                        end
                    end
                end
            end
        end
    end

    // The state registers change only on an accepted tick, which happens only
    // when the result slot is free or drains in the same cycle, so they double
    // as the result register.
    always_comb begin
        for (int i = 0; i < NUM_OUT; i++) begin
            o_levels[i] = '0;
        end
        for (int i = 0; i < NCH; i++) begin
            o_levels[i] = r_levels[i];
        end
    end

    assign o_lit_pattern = r_pattern;

endmodule

// ----- hdl/led_group_animator_top.sv -----
// Top level of the LED group animator: configuration registers and animation core.
// Depends on lga_pkg, lga_cfg and lga_core.
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// -------   -------------------------  -------------------------------------------
// tick in   i_valid / o_ready          i_anim_mode, i_led_mask, i_period_ms
// result    o_valid / i_ready          o_level_0 .. o_level_3, o_lit_pattern
// config    psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// One tick is accepted per clock cycle unless the consumer stalls. Its result
// appears in the cycle after acceptance; the path in between is one countdown
// compare, one fade add and the 8 by 8 brightness square. The result register
// holds a result while the consumer stalls, and a new tick is accepted in any
// cycle in which that register is empty or is being read. Reset is synchronous
// and active low; it restores the registers to full brightness with all
// channels present and clears the pattern, the levels and the countdown.

module led_group_animator_top #(
    parameter int CHANNELS = lga_pkg::CHANNELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Tick transactions.
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_anim_mode,
    input  logic [3:0]                   i_led_mask,
    input  logic [lga_pkg::PERIOD_W-1:0] i_period_ms,
    // Result transactions.
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lga_pkg::LEVEL_W-1:0]  o_level_0,
    output logic [lga_pkg::LEVEL_W-1:0]  o_level_1,
    output logic [lga_pkg::LEVEL_W-1:0]  o_level_2,
    output logic [lga_pkg::LEVEL_W-1:0]  o_level_3,
    output logic [3:0]                   o_lit_pattern,
    // Register port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lga_pkg::ADDR_W-1:0]   paddr,
    input  logic [lga_pkg::DATA_W-1:0]   pwdata,
    output logic [lga_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import lga_pkg::*;

    t_cfg                             w_cfg;
    logic [NUM_OUT-1:0][LEVEL_W-1:0]  w_levels;

    // Register 0 is the maximum brightness, register 1 the present channels.
    lga_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The core runs the countdown, the mode logic and the fade, and keeps the
    // stored level of each channel. A channel that is not present keeps its
    // level; channels beyond the parameter read as zero.
    lga_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_anim_mode   (i_anim_mode),
        .i_led_mask    (i_led_mask),
        .i_period_ms   (i_period_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_levels      (w_levels),
        .o_lit_pattern (o_lit_pattern)
    );

    assign o_level_0 = w_levels[0];
    assign o_level_1 = w_levels[1];
    assign o_level_2 = w_levels[2];
    assign o_level_3 = w_levels[3];

endmodule

// ----- hdl/lga_checker.sv -----
// Port-level checks of the LED group animator, bound to its top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lga_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_level_0,
    input logic [15:0] o_level_1,
    input logic [15:0] o_level_2,
    input logic [15:0] o_level_3,
    input logic [3:0]  o_lit_pattern
);

    // A stalled result keeps its values.
    `LGA_ASSERT(a_result_hold, o_valid && !i_ready |=> o_valid && $stable(o_level_0) && $stable(o_level_1) && $stable(o_level_2) && $stable(o_level_3) && $stable(o_lit_pattern), "result changed while stalled")

    // An empty result slot never blocks the tick channel.
    `LGA_ASSERT(a_ready_when_empty, !o_valid |-> o_ready, "tick blocked with empty result slot")

    // Every accepted tick produces a result in the next cycle.
    `LGA_ASSERT(a_result_follows, i_valid && o_ready |=> o_valid, "accepted tick gave no result")

    // The pattern moves only as the result of an accepted tick.
    `LGA_ASSERT(a_pattern_by_tick, !(i_valid && o_ready) |=> $stable(o_lit_pattern), "pattern changed without a tick")

endmodule

bind led_group_animator_top lga_checker u_lga_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_level_0     (o_level_0),
    .o_level_1     (o_level_1),
    .o_level_2     (o_level_2),
    .o_level_3     (o_level_3),
    .o_lit_pattern (o_lit_pattern)
);

// ----- tb/led_group_animator_top_tb.sv -----
// Self-checking testbench for led_group_animator_top: tick stream in, level stream out.
// Depends on lga_pkg and led_group_animator_top.
`timescale 1ns / 1ps

module led_group_animator_top_tb;
    import lga_pkg::*;

    // Value of the last-mode tracker before the first mode has been seen.
    localparam logic [2:0] NO_MODE_YET = 3'd4;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_TICKS = 36;
    localparam int PRESSURE_CYCLES = 64;

    // One result transaction: four channel levels and the lit pattern.
    typedef struct packed {
        logic [NUM_OUT-1:0][LEVEL_W-1:0] level;
        logic [3:0]                      lit_pattern;
    } t_anim_levels;

    // Tracks the animation state of the block. Every accepted tick advances the
    // state and queues the levels that the block must report for it; every
    // accepted result is compared against the oldest queued entry.
    class anim_tracker;
        logic [BRIGHT_W-1:0]            max_bright;
        logic [NUM_OUT-1:0]             present;
        logic [2:0]                     last_mode;
        logic [3:0]                     pattern;
        logic [BRIGHT_W-1:0]            bright;
        bit                             rising;
        logic [PERIOD_W-1:0]            ticks_left;
        logic [NUM_OUT-1:0][LEVEL_W-1:0] levels;
        t_anim_levels                   expected_levels[$];
        int                             errors;

        function new();
            max_bright = BRIGHT_MAX;
            present = PRESENT_ALL;
            last_mode = NO_MODE_YET;
            pattern = '0;
            bright = BRIGHT_MAX;
            rising = 1'b0;
            ticks_left = '0;
            levels = '0;
            errors = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_MAX_BRIGHT: max_bright = value[BRIGHT_W-1:0];
                REG_CH_PRESENT: present = value[NUM_OUT-1:0];
            endcase
        endfunction

        // One fade step: up or down by the step size, turning at either bound.
        // A brightness left above a lowered maximum saturates when rising.
        function void fade_brightness();
            int b;
            b = bright;
            if (rising) begin
                b = b + FADE_STEP;
                if (b >= max_bright) begin
                    rising = 1'b0;
                    b = max_bright;
                end
            end else if (b <= FADE_STEP) begin
                rising = 1'b1;
                b = 0;
            end else begin
                b = b - FADE_STEP;
            end
            bright = b[BRIGHT_W-1:0];
        endfunction

        function void note_tick(t_mode mode, logic [3:0] mask, logic [PERIOD_W-1:0] period);
            bit           act;
            logic [3:0]   next_pattern;
            t_anim_levels entry;
            act = 1'b0;
            if (ticks_left > 0)
                ticks_left = ticks_left - 1'b1;
            // With no channel wired the animation is frozen, but the countdown
            // above still runs down.
            if (present != '0) begin
                if ({1'b0, mode} != last_mode) begin
                    last_mode = {1'b0, mode};
                    ticks_left = '0;
                    bright = max_bright;
                    rising = 1'b0;
                    act = 1'b1;
                end else if (ticks_left == '0) begin
                    act = 1'b1;
                end
            end
            if (act) begin
                next_pattern = pattern;
                case (mode)
                    MODE_OFF:   next_pattern = '0;
                    MODE_SOLID: next_pattern = mask;
                    MODE_BLINK: begin
                        next_pattern = ~next_pattern & mask;
                        ticks_left = period;
                    end
                    MODE_FADE: begin
                        next_pattern = next_pattern & mask;
                        fade_brightness();
                        ticks_left = period;
                    end
                endcase
                pattern = next_pattern;
                // Absent channels keep whatever level they stored last.
                for (int i = 0; i < NUM_OUT; i++) begin
                    if (present[i])
                        levels[i] = pattern[i] ? LEVEL_W'(bright) * LEVEL_W'(bright) : '0;
                end
            end
            entry.level = levels;
            entry.lit_pattern = pattern;
            expected_levels.push_back(entry);
        endfunction

        function void check_levels(logic [NUM_OUT-1:0][LEVEL_W-1:0] got_level,
                                   logic [3:0] got_lit);
            t_anim_levels want;
            if (expected_levels.size() == 0) begin
                $display("%0t: result with no tick outstanding: expected none, got lit %h",
                         $time, got_lit);
                errors++;
                return;
            end
            want = expected_levels.pop_front();
            for (int i = 0; i < NUM_OUT; i++) begin
                if (got_level[i] !== want.level[i]) begin
                    $display("%0t: level_%0d expected %0d, got %0d",
                             $time, i, want.level[i], got_level[i]);
                    errors++;
                end
            end
            if (got_lit !== want.lit_pattern) begin
                $display("%0t: lit_pattern expected %h, got %h",
                         $time, want.lit_pattern, got_lit);
                errors++;
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [1:0]           i_anim_mode;
    logic [3:0]           i_led_mask;
    logic [PERIOD_W-1:0]  i_period_ms;
    logic                 o_valid;
    logic                 i_ready;
    logic [LEVEL_W-1:0]   o_level_0;
    logic [LEVEL_W-1:0]   o_level_1;
    logic [LEVEL_W-1:0]   o_level_2;
    logic [LEVEL_W-1:0]   o_level_3;
    logic [3:0]           o_lit_pattern;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // Flags from the stimulus process to the result sink.
    bit no_idle;
    bit pressure_go;

    anim_tracker tracker;

    led_group_animator_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_anim_mode   (i_anim_mode),
        .i_led_mask    (i_led_mask),
        .i_period_ms   (i_period_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_level_0     (o_level_0),
        .o_level_1     (o_level_1),
        .o_level_2     (o_level_2),
        .o_level_3     (o_level_3),
        .o_lit_pattern (o_lit_pattern),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 12 ns clock; rising edges at 6, 18, 30 ns and so on.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Both handshakes are observed at the rising edge, with the values that were
    // driven at the falling edge before it. The result is checked before the
    // tick of the same edge is noted; a tick cannot produce a result in the
    // cycle in which it is accepted, so the order only keeps the queue tidy.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                tracker.check_levels({o_level_3, o_level_2, o_level_1, o_level_0},
                                     o_lit_pattern);
            if (i_valid && o_ready)
                tracker.note_tick(t_mode'(i_anim_mode), i_led_mask, i_period_ms);
        end
    end

    // Result sink. It stalls at random, never while the stimulus asks for no
    // idle cycles, and once holds ready low for a long run of cycles so that
    // the result register fills and the block pushes back on the tick
    // channel.
    initial begin : result_sink
        int hold_left;
        bit pressure_done;
        hold_left = 0;
        pressure_done = 1'b0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_go && !pressure_done) begin
                hold_left = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (no_idle) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    // Offers one tick transaction and returns at the falling edge after it was
    // accepted. Entered at a falling edge. Valid is only dropped for idle cycles
    // before the tick is raised, so it never toggles within a step.
    task automatic send_tick(t_mode mode, logic [3:0] mask, logic [PERIOD_W-1:0] period);
        while (!no_idle && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_anim_mode <= mode;
        i_led_mask <= mask;
        i_period_ms <= period;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops offering ticks and waits until every expected result has come back,
    // then lets the pipeline settle before anything else happens.
    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (tracker.pending() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Writes one register on the APB port, then reads it back. Only the bits
    // that the register implements are compared.
    task automatic write_register(t_reg_idx idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] keep;
        keep = (idx == REG_MAX_BRIGHT) ? DATA_W'(BRIGHT_MAX) : DATA_W'(PRESENT_ALL);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & keep) !== (value & keep)) begin
            $display("%0t: register %s read back expected %h, got %h",
                     $time, idx.name(), value & keep, prdata & keep);
            tracker.errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    // Random ticks for one phase. Most of them come in runs of one mode with a
    // short period, so that blink toggles and fade sweeps actually happen; a
    // few long runs let the fade reach both ends of its range. The rest are
    // single ticks with every field random, which break the runs up.
    task automatic random_ticks(int n_ticks);
        int                  sent;
        int                  run_len;
        int                  pick;
        t_mode               mode;
        logic [3:0]          mask;
        logic [PERIOD_W-1:0] period;
        bit                  mask_varies;
        sent = 0;
        while (sent < n_ticks) begin
            if ($urandom_range(99) < 15) begin
                send_tick(t_mode'($urandom_range(3)), 4'($urandom), PERIOD_W'($urandom));
                sent++;
            end else begin
                mode = t_mode'($urandom_range(3));
                mask = 4'($urandom);
                mask_varies = ($urandom_range(3) == 0);
                pick = $urandom_range(99);
                if (pick < 60)
                    period = PERIOD_W'($urandom_range(4));
                else if (pick < 90)
                    period = PERIOD_W'($urandom_range(20));
                else
                    period = PERIOD_W'($urandom);
                run_len = ($urandom_range(4) == 0) ? $urandom_range(110, 40)
                                                   : $urandom_range(30, 1);
                for (int k = 0; k < run_len; k++) begin
                    if (mask_varies)
                        mask = 4'($urandom);
                    send_tick(mode, mask, period);
                end
                sent += run_len;
            end
        end
    endtask

    initial begin : stimulus
        logic [BRIGHT_W-1:0] phase_max [NUM_PHASES];
        logic [NUM_OUT-1:0]  phase_present [NUM_PHASES];
        phase_max = '{8'd255, 8'd0, 8'd5, 8'd128, 8'd255, 8'd200, 8'd60, 8'd255};
        phase_present = '{4'hF, 4'hF, 4'hA, 4'h3, 4'h0, 4'h1, 4'hF, 4'hF};
        // The last phase takes random register values.
        phase_max[NUM_PHASES-1] = BRIGHT_W'($urandom);
        phase_present[NUM_PHASES-1] = NUM_OUT'($urandom);

        tracker = new();
        no_idle = 1'b0;
        pressure_go = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_anim_mode = MODE_OFF;
        i_led_mask = '0;
        i_period_ms = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, starting at the reset values written explicitly.
        write_register(REG_MAX_BRIGHT, DATA_W'(BRIGHT_MAX));
        write_register(REG_CH_PRESENT, DATA_W'(PRESENT_ALL));
        // First tick after reset is always a mode change; solid then acts every tick.
        send_tick(MODE_SOLID, 4'hF, 16'hFFFF);
        send_tick(MODE_SOLID, 4'h5, 16'h0000);
        send_tick(MODE_OFF, 4'hF, 16'hFFFF);
        // Blink with a period of two: toggles on every other tick.
        repeat (4) send_tick(MODE_BLINK, 4'hF, 16'd2);
        repeat (2) send_tick(MODE_BLINK, 4'hA, 16'd0);
        // Fade starts from full brightness and steps down.
        repeat (3) send_tick(MODE_FADE, 4'hF, 16'd0);
        // Longest period: acts once, then waits.
        repeat (2) send_tick(MODE_FADE, 4'hF, 16'hFFFF);
        drain();

        // A maximum of zero: the fade turns at once.
        write_register(REG_MAX_BRIGHT, 32'd0);
        send_tick(MODE_SOLID, 4'h9, 16'h8000);
        repeat (2) send_tick(MODE_FADE, 4'hF, 16'd0);
        drain();

        // No channel wired: nothing changes, not even the remembered mode.
        write_register(REG_CH_PRESENT, 32'd0);
        send_tick(MODE_BLINK, 4'hF, 16'd3);
        send_tick(MODE_OFF, 4'h0, 16'd3);
        drain();

        // Two channels wired and a small maximum, so the fade hits its floor.
        write_register(REG_MAX_BRIGHT, 32'd7);
        write_register(REG_CH_PRESENT, 32'h6);
        send_tick(MODE_SOLID, 4'hF, 16'd0);
        repeat (3) send_tick(MODE_FADE, 4'hF, 16'd0);
        drain();

        // Lowering the maximum under a rising brightness: the next step saturates.
        write_register(REG_MAX_BRIGHT, 32'd3);
        repeat (2) send_tick(MODE_FADE, 4'hF, 16'd0);
        drain();

        // Random part, one register setting per phase. Phase 3 runs with no
        // idle cycles on either side; phase 5 opens with the long sink stall.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_register(REG_MAX_BRIGHT, DATA_W'(phase_max[p]));
            write_register(REG_CH_PRESENT, DATA_W'(phase_present[p]));
            no_idle = (p == 3);
            if (p == 5)
                pressure_go = 1'b1;
            random_ticks(PHASE_TICKS);
            drain();
        end
        no_idle = 1'b0;

        if (tracker.errors == 0)
            $display("led_group_animator_top_tb: done, clean");
        else
            $display("led_group_animator_top_tb: done, errors");
        $finish;
    end

    // A correct run needs well under a tenth of this.
    initial begin : watchdog
        #5_000_000;
        $display("led_group_animator_top_tb: done, errors");
        $finish;
    end

endmodule
